// ===== hdl/dlcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dlcs_pkg
// Shared types and constants of the DHCP lease client sequencer: channel
// widths, event and action codes, configuration layout, queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package dlcs_pkg;

    localparam int ADDR_W     = 32;
    localparam int MAC_W      = 48;
    localparam int TIME_W     = 32;
    localparam int OPT_W      = 4;
    localparam int RETRY_W    = 8;
    localparam int TRIES_W    = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W  = 280;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 216;
    localparam int M_TUSER_W  = 2;

    // option flag positions in options_present
    localparam int OPT_MASK_BIT   = 0;
    localparam int OPT_ROUTER_BIT = 1;
    localparam int OPT_LEASE_BIT  = 2;
    localparam int OPT_SRVID_BIT  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RENEW_TRIES = 8'd1;

    localparam logic [RETRY_W-1:0] RETRY_INTERVAL_RST  = 8'd5;
    localparam logic [TRIES_W-1:0] MAX_RENEW_TRIES_RST = 4'd3;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_OFFER = 2'd1,
        MODE_ACK   = 2'd2,
        MODE_OTHER = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_DISCOVER = 2'd1,
        ACT_REQUEST  = 2'd2,
        ACT_RENEW    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        EV_TICK   = 2'd0,
        EV_OFFER  = 2'd1,
        EV_ACK    = 2'd2,
        EV_IGNORE = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic [RETRY_W-1:0] retry_interval;
        logic [TRIES_W-1:0] max_renew_tries;
    } cfg_t;

    typedef struct packed {
        ev_kind_t            kind;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   lease_alarm;
        logic [TIME_W-1:0]   retry_alarm;
        logic [MAC_W-1:0]    peer_mac;
        logic [ADDR_W-1:0]   server_addr;
        logic [ADDR_W-1:0]   offered_addr;
        logic [ADDR_W-1:0]   netmask;
        logic [ADDR_W-1:0]   gateway;
        logic [ADDR_W-1:0]   server_ident;
        logic [OPT_W-1:0]    opts;
    } event_t;

    typedef struct packed {
        logic can_push;
        logic has_item;
    } q_status_t;

endpackage

`default_nettype wire

// ===== hdl/dlcs_front.sv =====
// ----------------------------------------------------------------------------
// dlcs_front
// Input side: unpacks an item, classifies it by mode and precomputes the
// lease and retry deadlines, then pushes the event into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcs_front (
    input  wire dlcs_pkg::cfg_t                  cfg,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire [dlcs_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    input  wire [dlcs_pkg::S_TUSER_W-1:0]        s_axis_tuser,
    input  wire dlcs_pkg::q_status_t             q_status,
    output logic                                 push,
    output dlcs_pkg::event_t                     push_data
);

    logic [dlcs_pkg::TIME_W-1:0] now;
    logic [dlcs_pkg::TIME_W-1:0] lease;

    assign now   = s_axis_tdata[31:0];
    assign lease = s_axis_tdata[239:208];

    assign s_axis_tready = q_status.can_push;
    assign push          = s_axis_tvalid && q_status.can_push;

    always_comb begin
        push_data.now          = now;
        push_data.peer_mac     = s_axis_tdata[79:32];
        push_data.server_addr  = s_axis_tdata[111:80];
        push_data.offered_addr = s_axis_tdata[143:112];
        push_data.netmask      = s_axis_tdata[175:144];
        push_data.gateway      = s_axis_tdata[207:176];
        push_data.server_ident = s_axis_tdata[271:240];
        push_data.opts         = s_axis_tdata[275:272];
        // deadlines wrap modulo 2^32
        push_data.lease_alarm  = now + (lease >> 1);
        push_data.retry_alarm  = now + dlcs_pkg::TIME_W'(cfg.retry_interval);
        unique case (dlcs_pkg::mode_t'(s_axis_tuser))
            dlcs_pkg::MODE_TICK:  push_data.kind = dlcs_pkg::EV_TICK;
            dlcs_pkg::MODE_OFFER: push_data.kind = dlcs_pkg::EV_OFFER;
            dlcs_pkg::MODE_ACK:   push_data.kind = dlcs_pkg::EV_ACK;
            default:              push_data.kind = dlcs_pkg::EV_IGNORE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/dlcs_queue.sv =====
// ----------------------------------------------------------------------------
// dlcs_queue
// Short register FIFO between front and back; lets each side stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push,
    input  wire [WIDTH-1:0]           push_data,
    input  wire                       pop,
    output logic [WIDTH-1:0]          pop_data,
    output dlcs_pkg::q_status_t       status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop_data        = mem_reg[rd_ptr_reg];
    assign status.can_push = (count_reg != CNT_W'(DEPTH));
    assign status.has_item = (count_reg != '0);

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dlcs_back.sv =====
// ----------------------------------------------------------------------------
// dlcs_back
// Lease state machine: takes one event a cycle from the queue unless the
// output stalls; updates phase, deadline and lease record; registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dlcs_back (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire dlcs_pkg::cfg_t                  cfg,
    input  wire dlcs_pkg::q_status_t             q_status,
    input  wire dlcs_pkg::event_t                ev,
    output logic                                 pop,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [dlcs_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic [dlcs_pkg::M_TUSER_W-1:0]       m_axis_tuser
);

    typedef enum logic [2:0] {
        PH_INIT       = 3'd0,
        PH_WAIT_OFFER = 3'd1,
        PH_WAIT_ACK   = 3'd2,
        PH_HAVE_LEASE = 3'd3,
        PH_RENEW      = 3'd4
    } phase_t;

    localparam int PAD_W = dlcs_pkg::M_TDATA_W - 1 - 5 * dlcs_pkg::ADDR_W - dlcs_pkg::MAC_W;

    phase_t                          phase_reg, phase_next;
    logic [dlcs_pkg::TIME_W-1:0]     alarm_reg, alarm_next;
    logic [dlcs_pkg::TRIES_W-1:0]    renew_count_reg, renew_count_next;
    logic [dlcs_pkg::MAC_W-1:0]      srv_mac_reg, srv_mac_next;
    logic [dlcs_pkg::ADDR_W-1:0]     srv_addr_reg, srv_addr_next;
    logic [dlcs_pkg::ADDR_W-1:0]     srv_ident_reg, srv_ident_next;
    logic [dlcs_pkg::ADDR_W-1:0]     own_addr_reg, own_addr_next;
    logic [dlcs_pkg::ADDR_W-1:0]     own_mask_reg, own_mask_next;
    logic [dlcs_pkg::ADDR_W-1:0]     own_gateway_reg, own_gateway_next;
    dlcs_pkg::action_t               action;
    logic                            due;

    logic                            m_valid_reg, m_valid_next;
    logic [dlcs_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [dlcs_pkg::M_TUSER_W-1:0]  m_user_reg, m_user_next;

    // take the next event whenever the output register is free or draining
    assign pop = q_status.has_item && (!m_valid_reg || m_axis_tready);
    assign due = (ev.now >= alarm_reg);

    always_comb begin
        phase_next       = phase_reg;
        alarm_next       = alarm_reg;
        renew_count_next = renew_count_reg;
        srv_mac_next     = srv_mac_reg;
        srv_addr_next    = srv_addr_reg;
        srv_ident_next   = srv_ident_reg;
        own_addr_next    = own_addr_reg;
        own_mask_next    = own_mask_reg;
        own_gateway_next = own_gateway_reg;
        action           = dlcs_pkg::ACT_NONE;

        if (pop) begin
            case (ev.kind)
                dlcs_pkg::EV_TICK: begin
                    unique case (phase_reg)
                        PH_INIT: begin
                            own_addr_next    = '0;
                            own_mask_next    = '0;
                            own_gateway_next = '0;
                            action           = dlcs_pkg::ACT_DISCOVER;
                            phase_next       = PH_WAIT_OFFER;
                        end
                        PH_HAVE_LEASE: begin
                            if (due) begin
                                phase_next       = PH_RENEW;
                                renew_count_next = '0;
                                alarm_next       = ev.now;
                            end
                        end
                        PH_RENEW: begin
                            if (due) begin
                                // retry limit spent: fall back to discover
                                if (renew_count_reg >= cfg.max_renew_tries) begin
                                    phase_next = PH_INIT;
                                end else begin
                                    action           = dlcs_pkg::ACT_RENEW;
                                    renew_count_next = renew_count_reg
                                                     + dlcs_pkg::TRIES_W'(1);
                                end
                                alarm_next = ev.retry_alarm;
                            end
                        end
                        default: ;
                    endcase
                end
                dlcs_pkg::EV_OFFER: begin
                    if (phase_reg == PH_WAIT_OFFER) begin
                        srv_mac_next  = ev.peer_mac;
                        srv_addr_next = ev.server_addr;
                        phase_next    = PH_WAIT_ACK;
                        action        = dlcs_pkg::ACT_REQUEST;
                    end
                end
                dlcs_pkg::EV_ACK: begin
                    if (phase_reg == PH_WAIT_ACK || phase_reg == PH_RENEW) begin
                        own_addr_next = ev.offered_addr;
                        if (ev.opts[dlcs_pkg::OPT_MASK_BIT]) begin
                            own_mask_next = ev.netmask;
                        end
                        if (ev.opts[dlcs_pkg::OPT_ROUTER_BIT]) begin
                            own_gateway_next = ev.gateway;
                        end
                        if (ev.opts[dlcs_pkg::OPT_LEASE_BIT]) begin
                            alarm_next = ev.lease_alarm;
                        end
                        if (ev.opts[dlcs_pkg::OPT_SRVID_BIT]) begin
                            srv_ident_next = ev.server_ident;
                        end
                        phase_next = PH_HAVE_LEASE;
                    end
                end
                default: ;
            endcase
        end

        m_valid_next = pop ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
        m_user_next  = pop ? dlcs_pkg::M_TUSER_W'(action) : m_user_reg;
        m_data_next  = pop ? {PAD_W'(0), srv_ident_next, srv_addr_next, srv_mac_next,
                              own_gateway_next, own_mask_next, own_addr_next,
                              phase_next == PH_HAVE_LEASE}
                           : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_INIT;
            alarm_reg       <= '0;
            renew_count_reg <= '0;
            srv_mac_reg     <= '0;
            srv_addr_reg    <= '0;
            srv_ident_reg   <= '0;
            own_addr_reg    <= '0;
            own_mask_reg    <= '0;
            own_gateway_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            alarm_reg       <= alarm_next;
            renew_count_reg <= renew_count_next;
            srv_mac_reg     <= srv_mac_next;
            srv_addr_reg    <= srv_addr_next;
            srv_ident_reg   <= srv_ident_next;
            own_addr_reg    <= own_addr_next;
            own_mask_reg    <= own_mask_next;
            own_gateway_reg <= own_gateway_next;
            m_valid_reg     <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== hdl/dhcp_lease_client_sequencer.sv =====
// ----------------------------------------------------------------------------
// dhcp_lease_client_sequencer
// DHCP client lease sequencer: ticks and parsed packets in, one result item
// per input item out (action to send plus the current lease record).
//
//   channel   | direction | handshake                | contents
//   s_axis    | in        | s_axis_tvalid/tready     | tick or parsed packet
//   m_axis    | out       | m_axis_tvalid/tready     | action and lease record
//   cfg       | in        | cfg_valid/cfg_ready      | register index and data
//
// One item per cycle sustained while the output is not stalled; the back end's
// state update (one compare and one register load per event) sets that rate. An
// accepted input passes through the queue into the registered result. Reset is
// synchronous and takes effect at once, no clearing pass. A stalled output fills
// the QUEUE_DEPTH-entry queue, and only then is s_axis_tready dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_lease_client_sequencer #(
    parameter int QUEUE_DEPTH = 2   // 2 to 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // now_sec, peer_mac, server_addr, offered_addr, netmask_opt, gateway_opt,
    // lease_opt, server_ident_opt, options_present, zero fill
    input  wire [dlcs_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // mode
    input  wire [dlcs_pkg::S_TUSER_W-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // have_lease, my_addr, my_netmask, my_gateway, lease_server_mac,
    // lease_server_addr, lease_server_ident, zero fill
    output logic [dlcs_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // action
    output logic [dlcs_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [dlcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [dlcs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    dlcs_pkg::cfg_t      cfg_reg;
    dlcs_pkg::q_status_t q_status;
    dlcs_pkg::event_t    push_data;
    dlcs_pkg::event_t    pop_data;
    logic                push;
    logic                pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_interval  <= dlcs_pkg::RETRY_INTERVAL_RST;
            cfg_reg.max_renew_tries <= dlcs_pkg::MAX_RENEW_TRIES_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dlcs_pkg::CFG_RETRY_INTERVAL:
                    cfg_reg.retry_interval <= cfg_data[dlcs_pkg::RETRY_W-1:0];
                dlcs_pkg::CFG_MAX_RENEW_TRIES:
                    cfg_reg.max_renew_tries <= cfg_data[dlcs_pkg::TRIES_W-1:0];
                default: ;
            endcase
        end
    end

    dlcs_front u_front (
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    dlcs_queue #(
        .WIDTH ($bits(dlcs_pkg::event_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    dlcs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .ev            (pop_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a discover always goes out with the address, mask and gateway cleared
    a_discover_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == dlcs_pkg::ACT_DISCOVER)
        |-> (m_axis_tdata[96:0] == '0))
        else $error("discover result with a lease record still set");

    // request and renew are only sent from phases other than have-lease
    a_send_without_lease: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == dlcs_pkg::ACT_REQUEST
                        || m_axis_tuser == dlcs_pkg::ACT_RENEW))
        |-> !m_axis_tdata[0])
        else $error("request or renew flagged as have-lease");

    // an item accepted into an empty queue is there on the next cycle
    a_queue_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !q_status.has_item)
        |=> q_status.has_item)
        else $error("accepted item missing from queue");

endmodule

`default_nettype wire

// ===== dv/dhcp_lease_client_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// dhcp_lease_client_sequencer_test
// Self-checking bench for the DHCP lease client sequencer. A short directed
// table walks the discover / request / bound / renew / fall-back cycle and
// the ignored-packet cases. Random lease cycles follow under several retry
// settings. Every result item is checked field by field against an in-bench
// model of the client lease state.
// ----------------------------------------------------------------------------
module dhcp_lease_client_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int N_PHASES        = 6;
    localparam int LIVE_PER_PHASE  = 200;
    localparam int PRESSURE_AT     = 100;
    localparam int MAX_PRINTED     = 100;
    localparam logic [dlcs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_IDX = 8'd7;

    // client lease phases as the bench tracks them
    typedef enum logic [2:0] {
        LP_START      = 3'd0,
        LP_OFFER_WAIT = 3'd1,
        LP_ACK_WAIT   = 3'd2,
        LP_BOUND      = 3'd3,
        LP_RENEWING   = 3'd4
    } lease_phase_t;

    typedef struct packed {
        dlcs_pkg::mode_t                 mode;
        logic [dlcs_pkg::TIME_W-1:0]     now;
        logic [dlcs_pkg::MAC_W-1:0]      mac;
        logic [dlcs_pkg::ADDR_W-1:0]     saddr;
        logic [dlcs_pkg::ADDR_W-1:0]     oaddr;
        logic [dlcs_pkg::ADDR_W-1:0]     mask;
        logic [dlcs_pkg::ADDR_W-1:0]     gw;
        logic [dlcs_pkg::TIME_W-1:0]     lease;
        logic [dlcs_pkg::ADDR_W-1:0]     sid;
        logic [dlcs_pkg::OPT_W-1:0]      opts;
    } dhcp_event_t;

    typedef struct packed {
        dlcs_pkg::action_t               act;
        logic                            bound;
        logic [dlcs_pkg::ADDR_W-1:0]     addr;
        logic [dlcs_pkg::ADDR_W-1:0]     mask;
        logic [dlcs_pkg::ADDR_W-1:0]     gw;
        logic [dlcs_pkg::MAC_W-1:0]      mac;
        logic [dlcs_pkg::ADDR_W-1:0]     saddr;
        logic [dlcs_pkg::ADDR_W-1:0]     sid;
    } lease_rec_t;

    typedef struct packed {
        dhcp_event_t       ev;
        logic              typed;
        dlcs_pkg::action_t act;
        logic              bound;
    } dir_row_t;

    logic                              aclk          = 1'b0;
    logic                              aresetn       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [dlcs_pkg::S_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic [dlcs_pkg::S_TUSER_W-1:0]    s_axis_tuser  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [dlcs_pkg::M_TDATA_W-1:0]    m_axis_tdata;
    logic [dlcs_pkg::M_TUSER_W-1:0]    m_axis_tuser;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [dlcs_pkg::CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [dlcs_pkg::CFG_DATA_W-1:0]   cfg_data      = '0;

    // lease client state and settings as predicted
    lease_phase_t                      cl_phase      = LP_START;
    logic [dlcs_pkg::TIME_W-1:0]       cl_alarm      = '0;
    logic [dlcs_pkg::TRIES_W-1:0]      cl_tries      = '0;
    logic [dlcs_pkg::MAC_W-1:0]        cl_mac        = '0;
    logic [dlcs_pkg::ADDR_W-1:0]       cl_srv        = '0;
    logic [dlcs_pkg::ADDR_W-1:0]       cl_ident      = '0;
    logic [dlcs_pkg::ADDR_W-1:0]       cl_addr       = '0;
    logic [dlcs_pkg::ADDR_W-1:0]       cl_mask       = '0;
    logic [dlcs_pkg::ADDR_W-1:0]       cl_gw         = '0;
    logic [dlcs_pkg::RETRY_W-1:0]      cfg_retry     = dlcs_pkg::RETRY_INTERVAL_RST;
    logic [dlcs_pkg::TRIES_W-1:0]      cfg_tries_max = dlcs_pkg::MAX_RENEW_TRIES_RST;

    lease_rec_t                        lease_records_due[$];
    dir_row_t                          dir_rows[$];
    logic [dlcs_pkg::TIME_W-1:0]       wall_sec      = '0;
    int                                mismatch_count = 0;
    int                                quiet_cycles   = 0;
    int                                in_idle_pct    = 0;
    int                                out_stall_pct  = 0;
    int                                out_hold_left  = 0;

    dhcp_lease_client_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name,
                               input logic [dlcs_pkg::MAC_W-1:0] got,
                               input logic [dlcs_pkg::MAC_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // advance the lease client by one event and return the record it reports
    task automatic next_lease_record(input dhcp_event_t e, output lease_rec_t r,
                                     output bit live);
        dlcs_pkg::action_t act;
        act  = dlcs_pkg::ACT_NONE;
        live = 1'b0;
        case (e.mode)
            dlcs_pkg::MODE_TICK: begin
                live = (cl_phase == LP_START || cl_phase == LP_BOUND ||
                        cl_phase == LP_RENEWING);
                case (cl_phase)
                    LP_START: begin
                        cl_addr  = '0;
                        cl_mask  = '0;
                        cl_gw    = '0;
                        act      = dlcs_pkg::ACT_DISCOVER;
                        cl_phase = LP_OFFER_WAIT;
                    end
                    LP_BOUND: begin
                        if (e.now >= cl_alarm) begin
                            cl_phase = LP_RENEWING;
                            cl_tries = '0;
                            cl_alarm = e.now;
                        end
                    end
                    LP_RENEWING: begin
                        if (e.now >= cl_alarm) begin
                            if (cl_tries >= cfg_tries_max) begin
                                cl_phase = LP_START;
                            end else begin
                                act      = dlcs_pkg::ACT_RENEW;
                                cl_tries = cl_tries + dlcs_pkg::TRIES_W'(1);
                            end
                            cl_alarm = e.now + {24'd0, cfg_retry};
                        end
                    end
                    default: ;
                endcase
            end
            dlcs_pkg::MODE_OFFER: begin
                if (cl_phase == LP_OFFER_WAIT) begin
                    cl_mac   = e.mac;
                    cl_srv   = e.saddr;
                    cl_phase = LP_ACK_WAIT;
                    act      = dlcs_pkg::ACT_REQUEST;
                    live     = 1'b1;
                end
            end
            dlcs_pkg::MODE_ACK: begin
                if (cl_phase == LP_ACK_WAIT || cl_phase == LP_RENEWING) begin
                    cl_addr = e.oaddr;
                    if (e.opts[dlcs_pkg::OPT_MASK_BIT])   cl_mask  = e.mask;
                    if (e.opts[dlcs_pkg::OPT_ROUTER_BIT]) cl_gw    = e.gw;
                    if (e.opts[dlcs_pkg::OPT_LEASE_BIT])  cl_alarm = e.now + (e.lease >> 1);
                    if (e.opts[dlcs_pkg::OPT_SRVID_BIT])  cl_ident = e.sid;
                    cl_phase = LP_BOUND;
                    live     = 1'b1;
                end
            end
            default: ;
        endcase
        r.act   = act;
        r.bound = (cl_phase == LP_BOUND);
        r.addr  = cl_addr;
        r.mask  = cl_mask;
        r.gw    = cl_gw;
        r.mac   = cl_mac;
        r.saddr = cl_srv;
        r.sid   = cl_ident;
    endtask

    function automatic dir_row_t mk_row(dlcs_pkg::mode_t mode,
                                        logic [dlcs_pkg::TIME_W-1:0] now,
                                        logic [dlcs_pkg::MAC_W-1:0] mac,
                                        logic [dlcs_pkg::ADDR_W-1:0] base,
                                        logic [dlcs_pkg::TIME_W-1:0] lease,
                                        logic [dlcs_pkg::OPT_W-1:0] opts,
                                        logic typed, dlcs_pkg::action_t act,
                                        logic bound);
        dir_row_t row;
        row.ev.mode  = mode;
        row.ev.now   = now;
        row.ev.mac   = mac;
        row.ev.saddr = base;
        row.ev.oaddr = base ^ 32'h5A5A_5A5A;
        row.ev.mask  = base ^ 32'hFFFF_0000;
        row.ev.gw    = base ^ 32'h00FF_00FF;
        row.ev.lease = lease;
        row.ev.sid   = base ^ 32'h3C3C_C3C3;
        row.ev.opts  = opts;
        row.typed    = typed;
        row.act      = act;
        row.bound    = bound;
        return row;
    endfunction

    // mostly well-formed lease traffic for the current phase, some noise
    function automatic dhcp_event_t draw_event();
        dhcp_event_t e;
        e.mac   = {16'($urandom), 32'($urandom)};
        e.saddr = $urandom;
        e.oaddr = $urandom;
        e.mask  = $urandom;
        e.gw    = $urandom;
        e.sid   = $urandom;
        e.opts  = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) != 0)
            e.opts[dlcs_pkg::OPT_LEASE_BIT] = 1'b1;
        e.lease = ($urandom_range(0, 15) == 0) ? 32'($urandom) : 32'($urandom_range(0, 80));
        if ($urandom_range(0, 99) < 10) begin
            e.mode = dlcs_pkg::mode_t'($urandom_range(0, 3));
            e.now  = $urandom;
            return e;
        end
        case (cl_phase)
            LP_OFFER_WAIT: e.mode = dlcs_pkg::MODE_OFFER;
            LP_ACK_WAIT:   e.mode = dlcs_pkg::MODE_ACK;
            LP_RENEWING:   e.mode = ($urandom_range(0, 4) == 0) ? dlcs_pkg::MODE_ACK
                                                                : dlcs_pkg::MODE_TICK;
            default:       e.mode = dlcs_pkg::MODE_TICK;
        endcase
        if (e.mode == dlcs_pkg::MODE_TICK) begin
            if ($urandom_range(0, 29) == 0)
                wall_sec = $urandom;
            else
                wall_sec = wall_sec + 32'($urandom_range(0, int'(cfg_retry) + 8));
        end
        e.now = wall_sec;
        return e;
    endfunction

    task automatic push_event(input dhcp_event_t e, input logic typed,
                              input dlcs_pkg::action_t t_act,
                              input logic t_bound, output bit live);
        lease_rec_t rec;
        s_axis_tdata  <= {4'd0, e.opts, e.sid, e.lease, e.gw, e.mask, e.oaddr,
                          e.saddr, e.mac, e.now};
        s_axis_tuser  <= e.mode;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        next_lease_record(e, rec, live);
        if (typed) begin
            rec.act   = t_act;
            rec.bound = t_bound;
        end
        lease_records_due.push_back(rec);
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < in_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // hold the input until every outstanding result has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (lease_records_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [dlcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dlcs_pkg::CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == dlcs_pkg::CFG_RETRY_INTERVAL)
            cfg_retry = data;
        else if (idx == dlcs_pkg::CFG_MAX_RENEW_TRIES)
            cfg_tries_max = data[dlcs_pkg::TRIES_W-1:0];
        @(posedge aclk);
    endtask

    // result checker and output stall generator
    always @(posedge aclk) begin
        lease_rec_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (lease_records_due.size() == 0) begin
                report_mismatch("result item with nothing outstanding");
            end else begin
                want = lease_records_due.pop_front();
                check_field("action", 48'(m_axis_tuser), 48'(want.act));
                check_field("have_lease", 48'(m_axis_tdata[0]), 48'(want.bound));
                check_field("my_addr", 48'(m_axis_tdata[32:1]), 48'(want.addr));
                check_field("my_netmask", 48'(m_axis_tdata[64:33]), 48'(want.mask));
                check_field("my_gateway", 48'(m_axis_tdata[96:65]), 48'(want.gw));
                check_field("lease_server_mac", m_axis_tdata[144:97], want.mac);
                check_field("lease_server_addr", 48'(m_axis_tdata[176:145]),
                            48'(want.saddr));
                check_field("lease_server_ident", 48'(m_axis_tdata[208:177]),
                            48'(want.sid));
            end
        end
        if (out_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            out_hold_left <= out_hold_left - 1;
        end else if ($urandom_range(0, 99) < out_stall_pct) begin
            m_axis_tready <= 1'b0;
            out_hold_left <= $urandom_range(0, 14);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [dlcs_pkg::RETRY_W-1:0] retry_plan [N_PHASES];
        logic [dlcs_pkg::TRIES_W-1:0] tries_plan [N_PHASES];
        dhcp_event_t                  ev;
        bit                           live;
        int                           live_seen;
        int                           sent;

        retry_plan = '{8'd5, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
        tries_plan = '{4'd3, 4'd0, 4'd15, 4'd15, 4'd0, 4'd0};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: retry 5 s, 3 renew tries
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OTHER, 32'h0, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OFFER, 32'h0, {dlcs_pkg::MAC_W{1'b1}},
                                  32'hFFFF_FFFF, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_ACK, 32'h0, 48'h0, 32'h1234_5678,
                                  32'hFFFF_FFFF, 4'hF, 1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'h0, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_DISCOVER, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'h0, 32'h0, 32'h0,
                                  4'h0, 1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_ACK, 32'h0, 48'h0, 32'hFFFF_FFFF, 32'h10,
                                  4'hF, 1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OTHER, 32'hFFFF_FFFF,
                                  {dlcs_pkg::MAC_W{1'b1}}, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 4'hF, 1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OFFER, 32'h0, {dlcs_pkg::MAC_W{1'b1}},
                                  32'hFFFF_FFFF, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_REQUEST, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OFFER, 32'h0, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'h8000_0000, 48'h0, 32'h0, 32'h0,
                                  4'h0, 1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OTHER, 32'h0, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_NONE, 1'b0));
        // lease of all ones: half of it pushes the alarm past the wrap
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_ACK, 32'hFFFF_FFF0, 48'h0, 32'h0,
                                  32'hFFFF_FFFF, 4'hF, 1'b1, dlcs_pkg::ACT_NONE, 1'b1));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'h0, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'h0, 32'h0, 32'h0,
                                  4'h0, 1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'hFFFF_FFFF, 48'h0, 32'h0, 32'h0,
                                  4'h0, 1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'd3, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'd4, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'd9, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        // renew tries spent: fall back to discover
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'd14, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'd15, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_DISCOVER, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OFFER, 32'd15, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b1, dlcs_pkg::ACT_REQUEST, 1'b0));
        // ack without any option keeps the old alarm
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_ACK, 32'd16, 48'h0, 32'hFFFF_FFFF,
                                  32'd1000, 4'h0, 1'b1, dlcs_pkg::ACT_NONE, 1'b1));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_TICK, 32'd100, 48'h0, 32'h0, 32'h0, 4'h0,
                                  1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_ACK, 32'd50, 48'h0, 32'h8000_0001, 32'h0,
                                  4'hA, 1'b0, dlcs_pkg::ACT_NONE, 1'b0));
        dir_rows.push_back(mk_row(dlcs_pkg::MODE_OFFER, 32'd51, {dlcs_pkg::MAC_W{1'b1}},
                                  32'h7FFF_FFFE, 32'h0, 4'h0,
                                  1'b0, dlcs_pkg::ACT_NONE, 1'b0));

        in_idle_pct   = 20;
        out_stall_pct = 20;
        foreach (dir_rows[i]) begin
            push_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].act,
                       dir_rows[i].bound, live);
            sender_gap();
        end
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES - 1) begin
                write_reg(dlcs_pkg::CFG_RETRY_INTERVAL, 8'($urandom_range(1, 20)));
                write_reg(dlcs_pkg::CFG_MAX_RENEW_TRIES,
                          {4'($urandom), 4'($urandom_range(1, 6))});
            end else if (p > 0) begin
                write_reg(dlcs_pkg::CFG_RETRY_INTERVAL, retry_plan[p]);
                write_reg(dlcs_pkg::CFG_MAX_RENEW_TRIES, {4'($urandom), tries_plan[p]});
                if (p == 2)
                    write_reg(CFG_UNMAPPED_IDX, 8'($urandom));
            end
            live_seen = 0;
            sent      = 0;
            while (live_seen < LIVE_PER_PHASE) begin
                // re-pick the idle rates now and then; none in the last phase
                if (sent % 64 == 0) begin
                    if (p == N_PHASES - 1) begin
                        in_idle_pct   = 0;
                        out_stall_pct = 0;
                    end else begin
                        in_idle_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                        out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                    end
                end
                if (sent == PRESSURE_AT)
                    settle();
                ev = draw_event();
                push_event(ev, 1'b0, dlcs_pkg::ACT_NONE, 1'b0, live);
                if (live)
                    live_seen++;
                sent++;
                sender_gap();
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== dhcp_lease_client_sequencer.f =====
hdl/dlcs_pkg.sv
hdl/dlcs_front.sv
hdl/dlcs_queue.sv
hdl/dlcs_back.sv
hdl/dhcp_lease_client_sequencer.sv
dv/dhcp_lease_client_sequencer_test.sv
